/* src/assert_macros.svh */
// Assertion macros shared by the encoder RTL.
// TFE_ASSERT checks a property on every rising edge of clk_i outside reset.
// TFE_ASSERT_NEVER checks that an expression is never true outside reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TFE_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: assertion failed");
`define TFE_ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("%m: forbidden condition seen");
`else
`define TFE_ASSERT(label, prop)
`define TFE_ASSERT_NEVER(label, expr)
`endif
`endif

/* src/tfe_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfe_pkg: shared types and constants of the tire frame encoder
// Register map, pipeline stage payloads, line format constants and the
// bytewise CRC-8 update.
// ----------------------------------------------------------------------------
package tfe_pkg;

  localparam int unsigned ADDR_W       = 4;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned CHUNK_W      = 64;
  localparam int unsigned CHUNKS       = 3;
  localparam int unsigned LINE_W       = CHUNK_W * CHUNKS;
  localparam int unsigned CODED_BITS   = 72;
  localparam int unsigned PREAMBLE_LEN = 14;
  localparam int unsigned TRAILER_LEN  = 3;
  localparam int unsigned LINE_LEN     = PREAMBLE_LEN + 2 * CODED_BITS + TRAILER_LEN;
  localparam int unsigned LAST_LEN     = LINE_LEN - CHUNK_W * (CHUNKS - 1);

  localparam logic [PREAMBLE_LEN-1:0] PREAMBLE = 14'b01010101001111;
  localparam logic [7:0] CRC_POLY = 8'h07;
  localparam logic [7:0] CRC_INIT = 8'h80;

  localparam logic [6:0] FULL_BITS = 7'(CHUNK_W);
  localparam logic [6:0] LAST_BITS = 7'(LAST_LEN);
  localparam logic [1:0] LAST_IDX  = 2'(CHUNKS - 1);

  localparam logic [15:0] P_GAIN_RST = 16'd4096;
  localparam logic signed [12:0] P_BIAS_RST = 13'sd0;
  localparam logic signed [7:0]  T_BIAS_RST = 8'sd0;

  typedef enum logic [1:0] {
    REG_PRESSURE_GAIN    = 2'd0,
    REG_PRESSURE_BIAS    = 2'd1,
    REG_TEMPERATURE_BIAS = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [15:0]        p_gain;
    logic signed [12:0] p_bias;
    logic signed [7:0]  t_bias;
  } cfg_t;

  typedef struct packed {
    logic [7:0]        status_byte;
    logic [31:0]       sensor_id;
    logic [13:0]       pressure_value;
    logic signed [8:0] temperature_value;
  } reading_t;

  // After the first stage: clamped pressure sum, temperature code.
  typedef struct packed {
    logic [7:0]  status;
    logic [31:0] id;
    logic [14:0] p_pos;
    logic [7:0]  t_code;
    logic [7:0]  crc;
  } st1_t;

  // After the multiplier stage.
  typedef struct packed {
    logic [7:0]  status;
    logic [31:0] id;
    logic [14:0] p_prod;
    logic [7:0]  t_code;
    logic [7:0]  crc;
  } scl_t;

  typedef struct packed {
    logic [63:0] frame;
    logic [7:0]  crc;
  } frm_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

/* src/tfe_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfe_if: valid/ready channels of the tire frame encoder
// tfe_in_if carries one tire reading per beat, tfe_out_if one line chunk.
// ----------------------------------------------------------------------------
interface tfe_in_if;
  logic              valid;
  logic              ready;
  logic [7:0]        status_byte;
  logic [31:0]       sensor_id;
  logic [13:0]       pressure_value;
  logic signed [8:0] temperature_value;

  modport source (output valid, status_byte, sensor_id, pressure_value,
                  temperature_value, input ready);
  modport sink (input valid, status_byte, sensor_id, pressure_value,
                temperature_value, output ready);
endinterface

interface tfe_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] line_chunk;
  logic [6:0]  chunk_bits;
  logic        last_chunk;

  modport source (output valid, line_chunk, chunk_bits, last_chunk, input ready);
  modport sink (input valid, line_chunk, chunk_bits, last_chunk, output ready);
endinterface

/* src/tfe_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfe_cfg_regs: APB register file
// Holds the pressure gain, pressure bias and temperature bias.
// ----------------------------------------------------------------------------
module tfe_cfg_regs import tfe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_PRESSURE_GAIN:    cfg_d.p_gain = pwdata[15:0];
        REG_PRESSURE_BIAS:    cfg_d.p_bias = pwdata[12:0];
        REG_TEMPERATURE_BIAS: cfg_d.t_bias = pwdata[7:0];
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PRESSURE_GAIN:    prdata = {16'b0, cfg_q.p_gain};
      REG_PRESSURE_BIAS:    prdata = {19'b0, cfg_q.p_bias};
      REG_TEMPERATURE_BIAS: prdata = {24'b0, cfg_q.t_bias};
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.p_gain <= P_GAIN_RST;
      cfg_q.p_bias <= P_BIAS_RST;
      cfg_q.t_bias <= T_BIAS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

/* src/tfe_scale.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfe_scale: reading scaling, pipeline stages one and two
// Stage one adds the biases and saturates the temperature code, stage two
// multiplies by the pressure gain. The CRC runs over the id bytes alongside.
// ----------------------------------------------------------------------------
module tfe_scale import tfe_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     valid_i,
  input  reading_t reading_i,
  output logic     ready_o,
  output logic     valid_o,
  output scl_t     data_o,
  input  logic     ready_i
);

  logic v1_q, v2_q;
  logic r1, r2;
  st1_t s1_q, s1_d;
  scl_t s2_q, s2_d;

  logic signed [15:0] p_sum;
  logic signed [9:0]  t_sum;
  logic [30:0]        prod;

  assign r2      = !v2_q || ready_i;
  assign r1      = !v1_q || r2;
  assign ready_o = r1;
  assign valid_o = v2_q;
  assign data_o  = s2_q;

  always_comb begin
    p_sum = $signed({2'b00, reading_i.pressure_value}) + 16'(cfg_i.p_bias);
    t_sum = 10'(reading_i.temperature_value) + 10'(cfg_i.t_bias);
    s1_d.status = reading_i.status_byte;
    s1_d.id     = reading_i.sensor_id;
    // A sum at or below zero gives a zero product, hence pressure code 0.
    s1_d.p_pos  = (p_sum > 16'sd0) ? p_sum[14:0] : '0;
    if (t_sum < 10'sd0) begin
      s1_d.t_code = 8'h00;
    end else if (t_sum > 10'sd255) begin
      s1_d.t_code = 8'hFF;
    end else begin
      s1_d.t_code = t_sum[7:0];
    end
    s1_d.crc = crc8_byte(crc8_byte(CRC_INIT, reading_i.sensor_id[31:24]),
                         reading_i.sensor_id[23:16]);
  end

  always_comb begin
    prod = 31'(s1_q.p_pos) * 31'(cfg_i.p_gain);
    s2_d.status = s1_q.status;
    s2_d.id     = s1_q.id;
    s2_d.p_prod = prod[30:16];
    s2_d.t_code = s1_q.t_code;
    s2_d.crc    = crc8_byte(crc8_byte(s1_q.crc, s1_q.id[15:8]), s1_q.id[7:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (r1) begin
        v1_q <= valid_i;
      end
      if (r2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (r1 && valid_i) begin
      s1_q <= s1_d;
    end
    if (r2 && v1_q) begin
      s2_q <= s2_d;
    end
  end

endmodule

/* src/tfe_frame_crc.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfe_frame_crc: frame assembly, pipeline stages three and four
// Stage three saturates the pressure code and lays out the 64-bit frame,
// stages three and four each fold two more frame bytes into the CRC.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tfe_frame_crc import tfe_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  scl_t data_i,
  output logic ready_o,
  output logic valid_o,
  output frm_t data_o,
  input  logic ready_i
);

  logic v3_q, v4_q;
  logic r3, r4;
  frm_t s3_q, s3_d;
  frm_t s4_q, s4_d;
  logic [7:0] p_code;

  assign r4      = !v4_q || ready_i;
  assign r3      = !v3_q || r4;
  assign ready_o = r3;
  assign valid_o = v4_q;
  assign data_o  = s4_q;

  always_comb begin
    p_code = (|data_i.p_prod[14:8]) ? 8'hFF : data_i.p_prod[7:0];
    s3_d.frame = {data_i.id, data_i.status[7], p_code, data_i.t_code,
                  data_i.status[6:0], ~p_code};
    s3_d.crc   = crc8_byte(crc8_byte(data_i.crc, s3_d.frame[31:24]), s3_d.frame[23:16]);
  end

  always_comb begin
    s4_d.frame = s3_q.frame;
    s4_d.crc   = crc8_byte(crc8_byte(s3_q.crc, s3_q.frame[15:8]), s3_q.frame[7:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (r3) begin
        v3_q <= valid_i;
      end
      if (r4) begin
        v4_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (r3 && valid_i) begin
      s3_q <= s3_d;
    end
    if (r4 && v3_q) begin
      s4_q <= s4_d;
    end
  end

  // A frame held back by the line stage must not change under it.
  `TFE_ASSERT(a_s4_hold, (v4_q && !ready_i) |=> (v4_q && $stable(s4_q)))

endmodule

/* src/tfe_line_out.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfe_line_out: differential Manchester coding and chunk output
// Codes frame and CRC behind the preamble into a 192-bit line register and
// shifts it out as three chunk beats.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tfe_line_out import tfe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  frm_t              data_i,
  output logic              ready_o,
  output logic              valid_o,
  output logic [CHUNK_W-1:0] line_chunk_o,
  output logic [6:0]        chunk_bits_o,
  output logic              last_chunk_o,
  input  logic              ready_i
);

  localparam int unsigned PAD_HI = LINE_W - 1 - LAST_LEN;
  localparam int unsigned PAD_LO = LINE_W - CHUNK_W;

  logic [LINE_W-1:0]     line_q, line_d;
  logic [1:0]            cnt_q;
  logic                  ov_q;
  logic [CODED_BITS-1:0] word;
  logic [CODED_BITS-1:0] par_incl, par_prev;
  logic                  last, beat, load;

  assign last    = (cnt_q == LAST_IDX);
  assign beat    = ov_q && ready_i;
  assign ready_o = !ov_q || (ready_i && last);
  assign load    = valid_i && ready_o;

  assign valid_o      = ov_q;
  assign line_chunk_o = line_q[LINE_W-1 -: CHUNK_W];
  assign chunk_bits_o = last ? LAST_BITS : FULL_BITS;
  assign last_chunk_o = last;

  assign word = {data_i.frame, data_i.crc};

  // The line level before coded bit k is the inverse of the parity of all
  // earlier bits, so each half bit follows from a prefix parity.
  always_comb begin
    for (int k = 0; k < CODED_BITS; k++) begin
      par_incl[k] = ^(word >> (CODED_BITS - 1 - k));
      par_prev[k] = ^(word >> (CODED_BITS - k));
    end
  end

  always_comb begin
    line_d = '0;
    line_d[LINE_W-1 -: PREAMBLE_LEN] = PREAMBLE;
    for (int k = 0; k < CODED_BITS; k++) begin
      line_d[LINE_W - 1 - PREAMBLE_LEN - 2 * k] = par_prev[k];
      line_d[LINE_W - 2 - PREAMBLE_LEN - 2 * k] = ~par_incl[k];
    end
    for (int t = 0; t < TRAILER_LEN; t++) begin
      line_d[LINE_W - 1 - PREAMBLE_LEN - 2 * CODED_BITS - t] = par_incl[CODED_BITS-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q  <= 1'b0;
      cnt_q <= '0;
    end else if (load) begin
      ov_q  <= 1'b1;
      cnt_q <= '0;
    end else if (beat) begin
      if (last) begin
        ov_q <= 1'b0;
      end
      cnt_q <= cnt_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      line_q <= line_d;
    end else if (beat) begin
      line_q <= {line_q[LINE_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}};
    end
  end

  `TFE_ASSERT(a_first_preamble, (ov_q && cnt_q == '0) |-> (line_q[LINE_W-1 -: PREAMBLE_LEN] == PREAMBLE))
  `TFE_ASSERT(a_step_chunk, (beat && !last) |=> (ov_q && cnt_q == $past(cnt_q) + 2'd1))
  `TFE_ASSERT(a_drain, (beat && last && !load) |=> !ov_q)
  `TFE_ASSERT_NEVER(a_pad_zero, ov_q && last && (line_q[PAD_HI:PAD_LO] != '0))

endmodule

/* src/tpms_frame_encoder_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpms_frame_encoder_core: tire reading to coded radio line
// Scales one reading to byte codes, builds frame and CRC-8, codes it in
// differential Manchester behind a preamble and sends 161 line bits.
// ----------------------------------------------------------------------------
//  channel    dir  handshake           beat carries
//  reading_i  in   valid/ready         status, sensor id, pressure, temperature
//  chunk_o    out  valid/ready         64 line bits, valid bit count, last flag
//  APB        in   psel/penable/pwrite three config registers at 0x0, 0x4, 0x8
//
//  A reading passes five register stages: bias add, gain multiply, frame
//  layout, CRC finish, line coding. Its first chunk comes straight from the
//  line coding register. Each frame leaves as three chunk beats, and the
//  line output register takes the next frame as the last beat leaves, so
//  the line output register sets the sustained rate.
//  Readings are accepted back to back while earlier ones are still in flight.
//  Reset clears the valid bits and the chunk counter and loads the register
//  defaults; no memory needs a clearing pass.
//  A stall on chunk_o holds the beat and backs up stage by stage.
// ----------------------------------------------------------------------------
module tpms_frame_encoder_core import tfe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  tfe_in_if.sink            reading_i,
  tfe_out_if.source         chunk_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t     cfg;
  reading_t reading;
  scl_t     scl_data;
  frm_t     frm_data;
  logic     scl_valid, scl_ready;
  logic     frm_valid, frm_ready;

  assign reading.status_byte       = reading_i.status_byte;
  assign reading.sensor_id         = reading_i.sensor_id;
  assign reading.pressure_value    = reading_i.pressure_value;
  assign reading.temperature_value = reading_i.temperature_value;

  tfe_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tfe_scale u_scale (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .valid_i   (reading_i.valid),
    .reading_i (reading),
    .ready_o   (reading_i.ready),
    .valid_o   (scl_valid),
    .data_o    (scl_data),
    .ready_i   (scl_ready)
  );

  tfe_frame_crc u_frame (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (scl_valid),
    .data_i  (scl_data),
    .ready_o (scl_ready),
    .valid_o (frm_valid),
    .data_o  (frm_data),
    .ready_i (frm_ready)
  );

  tfe_line_out u_line (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (frm_valid),
    .data_i       (frm_data),
    .ready_o      (frm_ready),
    .valid_o      (chunk_o.valid),
    .line_chunk_o (chunk_o.line_chunk),
    .chunk_bits_o (chunk_o.chunk_bits),
    .last_chunk_o (chunk_o.last_chunk),
    .ready_i      (chunk_o.ready)
  );

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the tire frame encoder core
// Feeds tire readings over the valid/ready input channel, changes the scaling
// registers over APB between phases, and checks every line chunk against a
// predicted frame with CRC-8, differential Manchester coding, preamble and
// trailer. Both channels idle at random, in changing proportions.
// ----------------------------------------------------------------------------
module tb_top;
  import tfe_pkg::*;

  localparam logic [ADDR_W-1:0] UNMAPPED_ADDR = 4'hC;

  typedef struct {
    logic [63:0] bits;
    logic [6:0]  count;
    logic        last;
  } line_chunk_t;

  class tire_line_scoreboard;
    int          p_gain;
    int          p_bias;
    int          t_bias;
    line_chunk_t expected_chunks[$];
    int unsigned errors;
    int unsigned chunks_seen;

    function new();
      p_gain = 4096;
      p_bias = 0;
      t_bias = 0;
      errors = 0;
      chunks_seen = 0;
    endfunction

    function void write_reg(logic [ADDR_W-1:0] addr, logic [31:0] data);
      case (addr[3:2])
        REG_PRESSURE_GAIN:    p_gain = int'(data[15:0]);
        REG_PRESSURE_BIAS:    p_bias = int'($signed(data[12:0]));
        REG_TEMPERATURE_BIAS: t_bias = int'($signed(data[7:0]));
        default: ;
      endcase
    endfunction

    // Builds the whole 161-bit line for one reading and queues its three chunks.
    function void note_reading(reading_t r);
      int           p_sum;
      int           t_sum;
      int           pos;
      longint       scaled;
      logic [7:0]   p_code;
      logic [7:0]   t_code;
      logic [7:0]   crc;
      logic [63:0]  frame;
      logic [71:0]  coded;
      logic [191:0] line;
      logic         lvl;
      line_chunk_t  beat;
      p_sum = int'(r.pressure_value) + p_bias;
      if (p_sum <= 0) begin
        p_code = 8'd0;
      end else begin
        scaled = (longint'(p_sum) * longint'(p_gain)) >>> 16;
        p_code = (scaled > 255) ? 8'd255 : 8'(scaled);
      end
      t_sum = int'($signed(r.temperature_value)) + t_bias;
      t_code = (t_sum < 0) ? 8'd0 : ((t_sum > 255) ? 8'd255 : 8'(t_sum));
      frame = {r.sensor_id, r.status_byte[7], p_code, t_code, r.status_byte[6:0], ~p_code};
      // Bit-serial CRC, equivalent to the bytewise form with MSB-first input.
      crc = CRC_INIT;
      for (int i = 63; i >= 0; i--) begin
        crc = {crc[6:0], 1'b0} ^ ((crc[7] ^ frame[i]) ? CRC_POLY : 8'h00);
      end
      coded = {frame, crc};
      line = '0;
      pos = 0;
      for (int i = PREAMBLE_LEN - 1; i >= 0; i--) begin
        line[191 - pos] = PREAMBLE[i];
        pos++;
      end
      lvl = 1'b1;
      for (int k = 71; k >= 0; k--) begin
        lvl = ~lvl;
        line[191 - pos] = lvl;
        pos++;
        if (!coded[k]) lvl = ~lvl;
        line[191 - pos] = lvl;
        pos++;
      end
      repeat (3) begin
        line[191 - pos] = ~lvl;
        pos++;
      end
      for (int c = 0; c < 3; c++) begin
        beat.bits  = line[191 - 64 * c -: 64];
        beat.count = (c < 2) ? 7'd64 : 7'(pos - 128);
        beat.last  = (c == 2);
        expected_chunks.push_back(beat);
      end
    endfunction

    function void check_chunk(logic [63:0] bits, logic [6:0] count, logic last);
      line_chunk_t exp_beat;
      chunks_seen++;
      if (expected_chunks.size() == 0) begin
        $display("%0t: unexpected chunk %h bits %0d last %0b", $time, bits, count, last);
        errors++;
        return;
      end
      exp_beat = expected_chunks.pop_front();
      if (bits !== exp_beat.bits) begin
        $display("%0t: chunk %0d line_chunk expected %h actual %h",
                 $time, chunks_seen, exp_beat.bits, bits);
        errors++;
      end
      if (count !== exp_beat.count) begin
        $display("%0t: chunk %0d chunk_bits expected %0d actual %0d",
                 $time, chunks_seen, exp_beat.count, count);
        errors++;
      end
      if (last !== exp_beat.last) begin
        $display("%0t: chunk %0d last_chunk expected %0b actual %0b",
                 $time, chunks_seen, exp_beat.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_chunks.size();
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int unsigned in_idle_pct;
  int unsigned out_idle_pct;

  tire_line_scoreboard sb;

  tfe_in_if  reading_bus ();
  tfe_out_if chunk_bus ();

  tpms_frame_encoder_core dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .reading_i (reading_bus),
    .chunk_o   (chunk_bus),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Chunk sink: check on each accepted beat, then decide the next ready.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (chunk_bus.valid && chunk_bus.ready) begin
        sb.check_chunk(chunk_bus.line_chunk, chunk_bus.chunk_bits, chunk_bus.last_chunk);
      end
      chunk_bus.ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end
  end

  task automatic send_reading(input reading_t r);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      reading_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    reading_bus.valid             <= 1'b1;
    reading_bus.status_byte       <= r.status_byte;
    reading_bus.sensor_id         <= r.sensor_id;
    reading_bus.pressure_value    <= r.pressure_value;
    reading_bus.temperature_value <= r.temperature_value;
    do @(posedge clk_i); while (!reading_bus.ready);
    sb.note_reading(r);
  endtask

  task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_reg(addr, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(input int gain, input int p_bias, input int t_bias);
    apb_write(ADDR_W'(REG_PRESSURE_GAIN) << 2, 32'(gain));
    apb_write(ADDR_W'(REG_PRESSURE_BIAS) << 2, 32'(p_bias));
    apb_write(ADDR_W'(REG_TEMPERATURE_BIAS) << 2, 32'(t_bias));
  endtask

  // Waits until every chunk has come out, plus the pipeline depth.
  task automatic drain();
    reading_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Random reading, often aimed at the zero and saturation points of the codes.
  function automatic reading_t random_reading();
    reading_t r;
    int       p;
    int       t;
    r.status_byte = 8'($urandom);
    r.sensor_id   = $urandom;
    case ($urandom_range(0, 3))
      0, 1: p = int'($urandom_range(0, 16383));
      2: p = -sb.p_bias + int'($urandom_range(0, 64)) - 32;
      default: begin
        if (sb.p_gain != 0)
          p = (256 * 65536) / sb.p_gain - sb.p_bias + int'($urandom_range(0, 64)) - 32;
        else
          p = int'($urandom_range(0, 16383));
      end
    endcase
    if (p < 0) p = 0;
    if (p > 16383) p = 16383;
    case ($urandom_range(0, 3))
      0, 1: t = int'($urandom_range(0, 383)) - 128;
      2: t = -sb.t_bias + int'($urandom_range(0, 6)) - 3;
      default: t = 255 - sb.t_bias + int'($urandom_range(0, 6)) - 3;
    endcase
    if (t < -128) t = -128;
    if (t > 255) t = 255;
    r.pressure_value    = 14'(p);
    r.temperature_value = 9'(t);
    return r;
  endfunction

  initial begin
    sb = new();
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    reading_bus.valid = 1'b0;
    reading_bus.status_byte = '0;
    reading_bus.sensor_id = '0;
    reading_bus.pressure_value = '0;
    reading_bus.temperature_value = '0;
    chunk_bus.ready = 1'b0;
    in_idle_pct = 21;
    out_idle_pct = 87;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed readings under the reset scaling: field extremes, code zero by
    // truncation, exact and overflowing pressure saturation, temperature clamps.
    send_reading('{8'h00, 32'h0000_0000, 14'd0,     9'sd0});
    send_reading('{8'hFF, 32'hFFFF_FFFF, 14'd16383, 9'sd255});
    send_reading('{8'h80, 32'hAAAA_AAAA, 14'd1,     -9'sd128});
    send_reading('{8'h7F, 32'h5555_5555, 14'd16,    -9'sd1});
    send_reading('{8'h01, 32'h1234_5678, 14'd4095,  9'sd100});
    send_reading('{8'hFE, 32'h8000_0000, 14'd4080,  9'sd254});
    send_reading('{8'h55, 32'h0000_0001, 14'd4096,  9'sd127});
    send_reading('{8'hAA, 32'h7FFF_FFFF, 14'd15,    9'sd1});
    send_reading('{8'h3C, 32'hDEAD_BEEF, 14'd8191,  -9'sd127});
    send_reading('{8'hC3, 32'h0F0F_0F0F, 14'd2048,  9'sd128});

    for (int phase = 0; phase < 6; phase++) begin
      if (phase > 0) begin
        drain();
        case (phase)
          1: begin
            // A write to an unmapped address must leave the registers alone.
            apb_write(UNMAPPED_ADDR, 32'hFFFF_FFFF);
            set_config(65535, 4095, 127);
          end
          2: set_config(0, -4096, -128);
          3: set_config(int'($urandom_range(0, 65535)), int'($urandom_range(0, 8191)) - 4096,
                        int'($urandom_range(0, 255)) - 128);
          4: set_config(4096 + int'($urandom_range(0, 2048)) - 1024,
                        -int'($urandom_range(0, 400)), int'($urandom_range(0, 255)) - 128);
          default: set_config(int'($urandom_range(0, 65535)),
                              int'($urandom_range(0, 8191)) - 4096,
                              int'($urandom_range(0, 255)) - 128);
        endcase
      end
      case (phase / 2)
        0: begin
          in_idle_pct = 21;
          out_idle_pct = 87;
        end
        1: begin
          in_idle_pct = 87;
          out_idle_pct = 21;
        end
        default: begin
          in_idle_pct = 0;
          out_idle_pct = 0;
        end
      endcase
      repeat (30) send_reading(random_reading());
    end

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[tpms_frame_encoder_core] OK");
    end else begin
      $display("[tpms_frame_encoder_core] ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("%0t: timeout with %0d chunks outstanding", $time, sb.pending());
    $display("[tpms_frame_encoder_core] ERROR");
    $finish;
  end

endmodule
